### src/rcsfd_pkg.sv
// ----------------------------------------------------------------------------
// rcsfd_pkg
// Shared types and constants of the serial RC frame decoder.
// ----------------------------------------------------------------------------
package rcsfd_pkg;

  localparam int FRAME_BYTES_DEF = 14;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0] SYNC_FIRST  = 8'h03;
  localparam logic [7:0] SYNC_SECOND = 8'h12;

  localparam int NUM_LANES = 5;
  localparam int CHAN_W    = 10;
  localparam int OUT_W     = 15;

  // lane order matches the result fields
  localparam int LANE_ROLL     = 0;
  localparam int LANE_THROTTLE = 1;
  localparam int LANE_PITCH    = 2;
  localparam int LANE_YAW      = 3;
  localparam int LANE_MODE     = 4;

  // divide by 85 via reciprocal multiply, exact for numerators below 2^21
  localparam int NUM_W     = 21;
  localparam int DIV_SHIFT = 28;
  localparam int MULT_W    = 22;
  localparam int PROD_W    = NUM_W + MULT_W;
  localparam logic [MULT_W-1:0] DIV_MULT = MULT_W'(((1 << DIV_SHIFT) + 84) / 85);

  localparam int OUT_DATA_W = ((NUM_LANES * OUT_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_HUNT  = 2'd0,
    ST_SYNC1 = 2'd1,
    ST_FRAME = 2'd2
  } sync_state_e;

  // raw 10-bit channel words, one per lane
  typedef logic [NUM_LANES-1:0][CHAN_W-1:0] chan_words_t;

endpackage

### src/rc_serial_frame_decoder.sv
// ----------------------------------------------------------------------------
// rc_serial_frame_decoder
// Serial RC receiver frame decoder: one byte per beat in, one scaled
// stick set out per complete frame.
// ----------------------------------------------------------------------------
// The slave stream takes one received byte per beat. A sync hunt waits for
// 0x03 then 0x12, then FrameBytes frame bytes are captured. The beat of the
// last frame byte pushes five raw channel words into a two-entry queue.
// The master stream gives one beat per frame with roll, throttle, pitch, yaw
// and mode level, each signed Q2.13, 15 bits.
// Throughput: one byte per cycle while s_axis_tready_o is high. The last frame
// byte is written into the queue, then passes the multiply stage and the output
// register before its result beat shows valid, each channel in its own multiplier.
// When the receiver stalls, results collect in the pipeline and the queue;
// only the last byte of a frame is held off, and only while the queue is
// full. Other bytes are always taken.
// Reset clears the sync state, the byte count, the queue and all valid
// flags; frame bytes are not cleared.
// ----------------------------------------------------------------------------
module rc_serial_frame_decoder
  import rcsfd_pkg::*;
#(
  parameter int FrameBytes = FRAME_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [7:0]            s_axis_tdata_i,  // rx_byte
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o   // roll, throttle, pitch, yaw, mode_level
);

  logic        push, q_full, q_valid, pop;
  chan_words_t push_data, q_data;

  rcsfd_front #(
    .FrameBytes(FrameBytes)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (s_axis_tvalid_i),
    .rx_byte_i  (s_axis_tdata_i),
    .rx_ready_o (s_axis_tready_o),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_data_o(push_data)
  );

  rcsfd_queue #(
    .Depth(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .data_o (q_data)
  );

  rcsfd_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_data_i (q_data),
    .pop_o    (pop),
    .m_valid_o(m_axis_tvalid_o),
    .m_data_o (m_axis_tdata_o),
    .m_ready_i(m_axis_tready_i)
  );

endmodule

### src/rcsfd_front.sv
// ----------------------------------------------------------------------------
// rcsfd_front
// Sync hunt, frame byte capture and channel word extraction.
// ----------------------------------------------------------------------------
module rcsfd_front
  import rcsfd_pkg::*;
#(
  parameter int FrameBytes = FRAME_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  input  logic [7:0]  rx_byte_i,
  output logic        rx_ready_o,
  input  logic        q_full_i,
  output logic        push_o,
  output chan_words_t push_data_o
);

  localparam int IdxW = $clog2(FrameBytes);

  sync_state_e state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0] store_q [FrameBytes];
  logic [7:0] frame [FrameBytes];
  logic last_byte;
  logic accept;

  assign last_byte  = (state_q == ST_FRAME) && (idx_q == IdxW'(FrameBytes - 1));
  assign rx_ready_o = !(last_byte && q_full_i);
  assign accept     = rx_valid_i && rx_ready_o;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_HUNT: begin
        if (accept && rx_byte_i == SYNC_FIRST) state_d = ST_SYNC1;
      end
      ST_SYNC1: begin
        if (accept) begin
          if (rx_byte_i == SYNC_SECOND) begin
            state_d = ST_FRAME;
            idx_d   = '0;
          end else begin
            state_d = ST_HUNT;
          end
        end
      end
      ST_FRAME: begin
        if (accept) begin
          idx_d = idx_q + IdxW'(1);
          if (last_byte) state_d = ST_HUNT;
        end
      end
      default: begin
        if (accept) state_d = ST_HUNT;
      end
    endcase
  end

  always_comb begin
    push_o = accept && last_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && state_q == ST_FRAME) store_q[idx_q] <= rx_byte_i;
  end

  // last byte bypasses the store
  always_comb begin
    frame = store_q;
    frame[FrameBytes-1] = rx_byte_i;
  end

  assign push_data_o[LANE_ROLL]     = {frame[0][1:0], frame[1]};
  assign push_data_o[LANE_THROTTLE] = {frame[2][1:0], frame[3]};
  assign push_data_o[LANE_PITCH]    = {frame[4][1:0], frame[5]};
  assign push_data_o[LANE_YAW]      = {frame[6][1:0], frame[7]};
  assign push_data_o[LANE_MODE]     = {frame[10][1:0], frame[11]};

endmodule

### src/rcsfd_queue.sv
// ----------------------------------------------------------------------------
// rcsfd_queue
// Short queue of channel words between front and back.
// ----------------------------------------------------------------------------
module rcsfd_queue
  import rcsfd_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  chan_words_t data_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        valid_o,
  output chan_words_t data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  chan_words_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    if (p == PtrW'(Depth - 1)) return '0;
    return p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= ptr_next(wr_q);
      if (do_pop) rd_q <= ptr_next(rd_q);
      if (do_push && !do_pop) cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

### src/rcsfd_back.sv
// ----------------------------------------------------------------------------
// rcsfd_back
// Per-channel scaling to Q2.13 in five lanes, two-stage pipeline.
// ----------------------------------------------------------------------------
module rcsfd_back
  import rcsfd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  chan_words_t           q_data_i,
  output logic                  pop_o,
  output logic                  m_valid_o,
  output logic [OUT_DATA_W-1:0] m_data_o,
  input  logic                  m_ready_i
);

  logic a_valid_q;
  logic [PROD_W-1:0] prod_q [NUM_LANES];
  logic [NUM_LANES-1:0] neg_q;
  logic out_valid_q;
  logic [OUT_DATA_W-1:0] out_q;
  logic out_ready, a_ready;

  logic signed [CHAN_W:0] x [NUM_LANES];
  logic signed [CHAN_W:0] v [NUM_LANES];
  logic [CHAN_W:0] v_abs [NUM_LANES];
  logic [NUM_W-1:0] num [NUM_LANES];
  logic [NUM_LANES-1:0] neg;
  logic [NUM_LANES*OUT_W-1:0] res;

  assign out_ready = !out_valid_q || m_ready_i;
  assign a_ready   = !a_valid_q || out_ready;
  assign pop_o     = q_valid_i && a_ready;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      x[i] = signed'((CHAN_W + 1)'({1'b0, q_data_i[i]}) - (CHAN_W + 1)'(512));
      v[i] = x[i];
      if (i == LANE_THROTTLE) v[i] = x[i] + (CHAN_W + 1)'(340);
      v_abs[i] = v[i][CHAN_W] ? (CHAN_W + 1)'(-v[i]) : (CHAN_W + 1)'(v[i]);
      // x*8192/340 = x*2048/85, (x+340)*8192/680 = (x+340)*1024/85
      if (i == LANE_THROTTLE) num[i] = {1'b0, v_abs[i][CHAN_W-1:0], 10'b0};
      else num[i] = {v_abs[i][CHAN_W-1:0], 11'b0};
      if (i == LANE_THROTTLE || i == LANE_MODE) neg[i] = v[i][CHAN_W];
      else neg[i] = !v[i][CHAN_W] && (v[i] != '0);
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      res[i*OUT_W +: OUT_W] = neg_q[i] ? OUT_W'(-prod_q[i][DIV_SHIFT +: OUT_W])
                                       : prod_q[i][DIV_SHIFT +: OUT_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= q_valid_i;
      if (out_ready) out_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        prod_q[i] <= PROD_W'(num[i]) * PROD_W'(DIV_MULT);
      end
      neg_q <= neg;
    end
    if (out_ready && a_valid_q) out_q <= OUT_DATA_W'(res);
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_q;

endmodule
